/* sv/htc_pkg.sv */
package htc_pkg;

    localparam int TIME_W     = 32;
    localparam int TEMP_W     = 9;
    localparam int SP_W       = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] KIND_UP      = 2'd0;
    localparam logic [1:0] KIND_DOWN    = 2'd1;
    localparam logic [1:0] KIND_SAMPLE  = 2'd2;
    localparam logic [1:0] KIND_COMMAND = 2'd3;

    localparam logic [1:0] COLOR_BLUE  = 2'd0;
    localparam logic [1:0] COLOR_RED   = 2'd1;
    localparam logic [1:0] COLOR_GREEN = 2'd2;
    localparam logic [1:0] COLOR_NONE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SP     = 3'd4;

    localparam logic [7:0]      HYST_RESET     = 8'd10;
    localparam logic [15:0]     DEBOUNCE_RESET = 16'd50;
    localparam logic [SP_W-1:0] STEP_RESET     = 7'd5;
    localparam logic [SP_W-1:0] MIN_SP_RESET   = 7'd0;
    localparam logic [SP_W-1:0] MAX_SP_RESET   = 7'd99;
    localparam logic [SP_W-1:0] SETPOINT_RESET = 7'd10;

    typedef struct packed {
        logic [1:0]               kind;
        logic [TIME_W-1:0]        time_stamp;
        logic signed [TEMP_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic [7:0]      hysteresis;
        logic [15:0]     debounce_ticks;
        logic [SP_W-1:0] step_size;
        logic [SP_W-1:0] min_setpoint;
        logic [SP_W-1:0] max_setpoint;
    } cfg_t;

endpackage

/* sv/htc_cfg_regs.sv */
module htc_cfg_regs
    import htc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_HYSTERESIS: cfg_next.hysteresis     = cfg_data[7:0];
                REG_DEBOUNCE:   cfg_next.debounce_ticks = cfg_data;
                REG_STEP_SIZE:  cfg_next.step_size      = cfg_data[SP_W-1:0];
                REG_MIN_SP:     cfg_next.min_setpoint   = cfg_data[SP_W-1:0];
                REG_MAX_SP:     cfg_next.max_setpoint   = cfg_data[SP_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hysteresis     <= HYST_RESET;
            cfg_reg.debounce_ticks <= DEBOUNCE_RESET;
            cfg_reg.step_size      <= STEP_RESET;
            cfg_reg.min_setpoint   <= MIN_SP_RESET;
            cfg_reg.max_setpoint   <= MAX_SP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* sv/htc_in_reg.sv */
module htc_in_reg
    import htc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               kind,
    input  logic [TIME_W-1:0]        time_stamp,
    input  logic signed [TEMP_W-1:0] value,
    output item_t                    item,
    output logic                     item_valid,
    input  logic                     item_take
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    assign in_stall   = valid_reg && !item_take;
    assign accept     = in_valid && !in_stall;
    assign item       = item_reg;
    assign item_valid = valid_reg;

    always_comb
    begin
        priority if (accept)
            valid_next = 1'b1;
        else if (item_take)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.kind       <= kind;
            item_reg.time_stamp <= time_stamp;
            item_reg.value      <= value;
        end
    end

endmodule

/* sv/htc_divide.sv */
module htc_divide
    import htc_pkg::*;
#(
    parameter int SAMPLES_PER_AVERAGE = 10,
    parameter int SUM_W               = 13
)
(
    input  logic signed [SUM_W-1:0]  sum,
    output logic signed [TEMP_W-1:0] quotient
);

    localparam int K      = SUM_W + 5;
    localparam int RECIP_W = K + 1;
    localparam int PROD_W = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << K) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE);

    logic              neg;
    logic [SUM_W-1:0]  mag;
    logic [PROD_W-1:0] prod;
    logic [8:0]        q_mag;

    always_comb
    begin
        neg   = sum[SUM_W-1];
        mag   = neg ? SUM_W'(-sum) : SUM_W'(sum);
        prod  = PROD_W'(mag) * PROD_W'(RECIP);
        q_mag = prod[K+8:K];
        quotient = TEMP_W'(neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag}));
    end

endmodule

/* sv/htc_core.sv */
module htc_core
    import htc_pkg::*;
#(
    parameter int SAMPLES_PER_AVERAGE = 10,
    parameter int TIME_BITS           = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  item_t                    item,
    input  logic                     item_valid,
    output logic                     item_take,
    input  cfg_t                     cfg,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     heater_on,
    output logic [1:0]               band_color,
    output logic [SP_W-1:0]          current_setpoint,
    output logic signed [TEMP_W-1:0] average_temp,
    output logic                     average_ready,
    output logic                     item_accepted
);

    localparam int SUM_W = $clog2(SAMPLES_PER_AVERAGE * 256) + 1;
    localparam int CNT_W = $clog2(SAMPLES_PER_AVERAGE + 1);
    localparam logic [CNT_W-1:0] COUNT_LAST = CNT_W'(SAMPLES_PER_AVERAGE);

    logic [SP_W-1:0]          setpoint_reg,   setpoint_next;
    logic [TIME_BITS-1:0]     up_last_reg,    up_last_next;
    logic [TIME_BITS-1:0]     down_last_reg,  down_last_next;
    logic signed [SUM_W-1:0]  sum_reg,        sum_next;
    logic [CNT_W-1:0]         count_reg,      count_next;
    logic signed [TEMP_W-1:0] last_avg_reg,   last_avg_next;
    logic                     heater_reg,     heater_next;
    logic [1:0]               color_reg,      color_next;
    logic                     out_valid_reg,  out_valid_next;
    logic                     ready_reg,      ready_next;
    logic                     accepted_reg,   accepted_next;
    logic [SP_W-1:0]          out_sp_reg;

    logic [TIME_BITS-1:0]     now;
    logic [TIME_BITS-1:0]     up_diff;
    logic [TIME_BITS-1:0]     down_diff;
    logic [TIME_BITS-1:0]     debounce_ext;
    logic                     up_ok;
    logic                     down_ok;
    logic [SP_W:0]            sp_up;
    logic [SP_W:0]            down_floor;
    logic                     up_room;
    logic                     down_room;
    logic signed [9:0]        val_ext;
    logic signed [9:0]        min_ext;
    logic signed [9:0]        max_ext;
    logic                     cmd_ok;
    logic signed [SUM_W-1:0]  sum_add;
    logic [CNT_W-1:0]         count_inc;
    logic                     group_done;
    logic signed [TEMP_W-1:0] avg_new;
    logic signed [10:0]       avg_ext;
    logic signed [10:0]       band_lo;
    logic signed [10:0]       band_hi;

    htc_divide #(
        .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
        .SUM_W               (SUM_W)
    ) u_divide (
        .sum      (sum_add),
        .quotient (avg_new)
    );

    assign item_take = item_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        now          = item.time_stamp[TIME_BITS-1:0];
        up_diff      = now - up_last_reg;
        down_diff    = now - down_last_reg;
        debounce_ext = TIME_BITS'(cfg.debounce_ticks);
        up_ok        = up_diff >= debounce_ext;
        down_ok      = down_diff >= debounce_ext;
        sp_up        = {1'b0, setpoint_reg} + {1'b0, cfg.step_size};
        down_floor   = {1'b0, cfg.min_setpoint} + {1'b0, cfg.step_size};
        up_room      = sp_up < {1'b0, cfg.max_setpoint};
        down_room    = {1'b0, setpoint_reg} > down_floor;
        val_ext      = 10'(item.value);
        min_ext      = $signed({3'b000, cfg.min_setpoint});
        max_ext      = $signed({3'b000, cfg.max_setpoint});
        cmd_ok       = (val_ext >= min_ext) && (val_ext <= max_ext);
        sum_add      = sum_reg + SUM_W'(item.value);
        count_inc    = count_reg + 1'b1;
        group_done   = count_inc == COUNT_LAST;
        avg_ext      = 11'(avg_new);
        band_lo      = $signed({4'b0000, setpoint_reg}) - $signed({3'b000, cfg.hysteresis});
        band_hi      = $signed({4'b0000, setpoint_reg}) + $signed({3'b000, cfg.hysteresis});
    end

    always_comb
    begin
        setpoint_next  = setpoint_reg;
        up_last_next   = up_last_reg;
        down_last_next = down_last_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        last_avg_next  = last_avg_reg;
        heater_next    = heater_reg;
        color_next     = color_reg;
        ready_next     = ready_reg;
        accepted_next  = accepted_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (item_take)
        begin
            out_valid_next = 1'b1;
            ready_next     = 1'b0;
            accepted_next  = 1'b0;
            unique case (item.kind)
                KIND_UP:
                begin
                    if (up_ok)
                    begin
                        up_last_next = now;
                        if (up_room)
                        begin
                            setpoint_next = sp_up[SP_W-1:0];
                            accepted_next = 1'b1;
                        end
                    end
                end
                KIND_DOWN:
                begin
                    if (down_ok)
                    begin
                        down_last_next = now;
                        if (down_room)
                        begin
                            setpoint_next = setpoint_reg - cfg.step_size;
                            accepted_next = 1'b1;
                        end
                    end
                end
                KIND_SAMPLE:
                begin
                    accepted_next = 1'b1;
                    if (group_done)
                    begin
                        sum_next      = '0;
                        count_next    = '0;
                        last_avg_next = avg_new;
                        ready_next    = 1'b1;
                        priority if (avg_ext < band_lo)
                        begin
                            heater_next = 1'b1;
                            color_next  = COLOR_BLUE;
                        end
                        else if (avg_ext > band_hi)
                        begin
                            heater_next = 1'b0;
                            color_next  = COLOR_RED;
                        end
                        else
                        begin
                            color_next = COLOR_GREEN;
                        end
                    end
                    else
                    begin
                        sum_next   = sum_add;
                        count_next = count_inc;
                    end
                end
                KIND_COMMAND:
                begin
                    if (cmd_ok)
                    begin
                        setpoint_next = item.value[SP_W-1:0];
                        accepted_next = 1'b1;
                    end
                end
                default:
                begin
                    accepted_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg  <= SETPOINT_RESET;
            up_last_reg   <= '0;
            down_last_reg <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            last_avg_reg  <= '0;
            heater_reg    <= 1'b0;
            color_reg     <= COLOR_NONE;
            out_valid_reg <= 1'b0;
            ready_reg     <= 1'b0;
            accepted_reg  <= 1'b0;
        end
        else
        begin
            setpoint_reg  <= setpoint_next;
            up_last_reg   <= up_last_next;
            down_last_reg <= down_last_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            last_avg_reg  <= last_avg_next;
            heater_reg    <= heater_next;
            color_reg     <= color_next;
            out_valid_reg <= out_valid_next;
            ready_reg     <= ready_next;
            accepted_reg  <= accepted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
            out_sp_reg <= setpoint_next;
    end

    assign out_valid        = out_valid_reg;
    assign heater_on        = heater_reg;
    assign band_color       = color_reg;
    assign current_setpoint = out_sp_reg;
    assign average_temp     = last_avg_reg;
    assign average_ready    = ready_reg;
    assign item_accepted    = accepted_reg;

endmodule

/* sv/hysteresis_thermostat_controller.sv */
// Thermostat controller with hysteresis.
// Input channel (in_valid / in_stall): one event per transfer; kind selects
// up press, down press, temperature sample or setpoint command, time_stamp
// is the tick count used for the per-button debounce window, value is the
// sample or the requested setpoint.
// Output channel (out_valid / out_stall): one result per input event with
// heater drive, band colour, setpoint, last group average and flags.
// Configuration channel (cfg_valid / cfg_ready): writes one register per
// transfer; cfg_ready is always high. Write only while the block is idle.
// Each event passes the input register, then the core state registers.
// Throughput: one event per cycle while out_stall is low, set by the single
// state update; an input register holds one event while the output waits.
// Reset: setpoint 10, no average yet (colour none), heater off, registers
// at their defaults. A stalled result holds its payload; the input side
// takes one more event, then stalls until the output frees up.
module hysteresis_thermostat_controller
    import htc_pkg::*;
#(
    parameter int SAMPLES_PER_AVERAGE = 10,
    parameter int TIME_BITS           = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               kind,
    input  logic [TIME_W-1:0]        time_stamp,
    input  logic signed [TEMP_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     heater_on,
    output logic [1:0]               band_color,
    output logic [SP_W-1:0]          current_setpoint,
    output logic signed [TEMP_W-1:0] average_temp,
    output logic                     average_ready,
    output logic                     item_accepted,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    cfg_t  cfg;
    item_t item;
    logic  item_valid;
    logic  item_take;

    htc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    htc_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .time_stamp (time_stamp),
        .value      (value),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take)
    );

    htc_core #(
        .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
        .TIME_BITS           (TIME_BITS)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .item             (item),
        .item_valid       (item_valid),
        .item_take        (item_take),
        .cfg              (cfg),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .heater_on        (heater_on),
        .band_color       (band_color),
        .current_setpoint (current_setpoint),
        .average_temp     (average_temp),
        .average_ready    (average_ready),
        .item_accepted    (item_accepted)
    );

endmodule

/* sv/htc_checker.sv */
module htc_checker
    import htc_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic                     heater_on,
    input logic [1:0]               band_color,
    input logic [SP_W-1:0]          current_setpoint,
    input logic signed [TEMP_W-1:0] average_temp,
    input logic                     average_ready,
    input logic                     item_accepted
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(heater_on) && $stable(band_color)
            && $stable(current_setpoint) && $stable(average_temp)
            && $stable(average_ready) && $stable(item_accepted))
        else $error("output payload changed while stalled");

    a_ready_taken: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && average_ready |-> item_accepted)
        else $error("group completed without the sample being taken");

    a_blue_heats: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && band_color == COLOR_BLUE |-> heater_on)
        else $error("below band but heater off");

    a_red_cools: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && band_color == COLOR_RED |-> !heater_on)
        else $error("above band but heater on");

    a_ready_colour: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && average_ready |-> band_color != COLOR_NONE)
        else $error("average ready with no band colour");

endmodule

bind hysteresis_thermostat_controller htc_checker u_htc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .heater_on        (heater_on),
    .band_color       (band_color),
    .current_setpoint (current_setpoint),
    .average_temp     (average_temp),
    .average_ready    (average_ready),
    .item_accepted    (item_accepted)
);
